[src/cdc_pkg.sv]
// shared types, constants and the month length table for the calendar date counter
`default_nettype none
package cdc_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int YEAR_WIDTH_DEF  = 12;

  // years are compared at this width so that 2100 fits at every year width
  localparam int YEAR_EXT_W = 16;
  localparam int C100_W     = 7;

  localparam logic [YEAR_EXT_W-1:0] MIN_YEAR      = 16'd1900;
  localparam logic [YEAR_EXT_W-1:0] MID_YEAR      = 16'd2000;
  localparam logic [YEAR_EXT_W-1:0] MAX_LOAD_YEAR = 16'd2100;
  localparam logic [7:0]            CENTURY_SPAN  = 8'd100;
  localparam logic [C100_W-1:0]     C100_LAST     = 7'd99;

  // century number modulo 4 for 1900, 2000 and 2100
  localparam logic [1:0] Q4_1900 = 2'd3;
  localparam logic [1:0] Q4_2000 = 2'd0;
  localparam logic [1:0] Q4_2100 = 2'd1;

  localparam logic [4:0] FIRST_DAY   = 5'd1;
  localparam logic [3:0] FIRST_MONTH = 4'd1;
  localparam logic [3:0] FEB         = 4'd2;
  localparam logic [3:0] DEC         = 4'd12;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_ADVANCE = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_MONTH = 3'd1,
    ST_BAD_YEAR  = 3'd2,
    ST_BAD_DAY   = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADV,
    S_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic adv;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic out_busy;
  } dp_stat_t;

  function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    unique case (month)
      4'd2:                            len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:         len = 5'd30;
      default:                         len = 5'd31;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

[src/cdc_in_if.sv]
// input channel: opcode and load or advance payload
`default_nettype none
interface cdc_in_if #(
  parameter int COUNT_WIDTH = cdc_pkg::COUNT_WIDTH_DEF,
  parameter int YEAR_WIDTH  = cdc_pkg::YEAR_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   opcode;
  logic [3:0]             new_month;
  logic [4:0]             new_day;
  logic [YEAR_WIDTH-1:0]  new_year;
  logic [COUNT_WIDTH-1:0] day_count;

  modport source (output valid, opcode, new_month, new_day, new_year, day_count,
                  input ready);
  modport sink   (input valid, opcode, new_month, new_day, new_year, day_count,
                  output ready);
endinterface
`default_nettype wire

[src/cdc_out_if.sv]
// result channel: date after the operation and status
`default_nettype none
interface cdc_out_if #(
  parameter int YEAR_WIDTH = cdc_pkg::YEAR_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic [4:0]            cur_day;
  logic [3:0]            cur_month;
  logic [YEAR_WIDTH-1:0] cur_year;
  logic [2:0]            status;

  modport source (output valid, cur_day, cur_month, cur_year, status, input ready);
  modport sink   (input valid, cur_day, cur_month, cur_year, status, output ready);
endinterface
`default_nettype wire

[src/cdc_ctrl.sv]
// controller state machine: sequences load, day stepping and result transfer
`default_nettype none
module cdc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_opcode,
  output logic                 in_ready,
  input  wire cdc_pkg::dp_stat_t dp_stat,
  output cdc_pkg::cmd_t        cmd
);

  cdc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cdc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cdc_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_opcode == cdc_pkg::OP_ADVANCE) ? cdc_pkg::S_ADV : cdc_pkg::S_FIN;
        end
      end
      cdc_pkg::S_ADV: begin
        if (dp_stat.done) begin
          state_nxt = cdc_pkg::S_FIN;
        end
      end
      cdc_pkg::S_FIN: begin
        if (!dp_stat.out_busy) begin
          state_nxt = cdc_pkg::S_IDLE;
        end
      end
      default: state_nxt = cdc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      cdc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid && (in_opcode == cdc_pkg::OP_LOAD);
        cmd.adv  = in_valid && (in_opcode == cdc_pkg::OP_ADVANCE);
      end
      cdc_pkg::S_ADV: begin
        cmd.step = !dp_stat.done;
      end
      cdc_pkg::S_FIN: begin
        cmd.emit = !dp_stat.out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

[src/cdc_dpath.sv]
// datapath: date registers, load checks, one-day stepper and output register
`default_nettype none
module cdc_dpath #(
  parameter int COUNT_WIDTH = cdc_pkg::COUNT_WIDTH_DEF,
  parameter int YEAR_WIDTH  = cdc_pkg::YEAR_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cdc_pkg::cmd_t          cmd,
  output cdc_pkg::dp_stat_t           dp_stat,
  input  wire logic [3:0]             in_month,
  input  wire logic [4:0]             in_day,
  input  wire logic [YEAR_WIDTH-1:0]  in_year,
  input  wire logic [COUNT_WIDTH-1:0] in_count,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [4:0]                  out_day,
  output logic [3:0]                  out_month,
  output logic [YEAR_WIDTH-1:0]       out_year,
  output logic [2:0]                  out_status
);

  localparam logic [YEAR_WIDTH-1:0] MAX_YEAR = {YEAR_WIDTH{1'b1}};

  logic [4:0]                  day_r;
  logic [3:0]                  month_r;
  logic [YEAR_WIDTH-1:0]       year_r;
  logic [cdc_pkg::C100_W-1:0]  c100_r;
  logic [1:0]                  q4_r;
  logic [COUNT_WIDTH-1:0]      cnt_r;
  cdc_pkg::status_t            stat_r;
  logic                        out_valid_r;
  logic [4:0]                  out_day_r;
  logic [3:0]                  out_month_r;
  logic [YEAR_WIDTH-1:0]       out_year_r;
  cdc_pkg::status_t            out_status_r;

  // load checks
  logic [cdc_pkg::YEAR_EXT_W-1:0] ld_year_ext;
  logic [7:0]                     ld_ofs;
  logic                           ld_leap;
  cdc_pkg::status_t               ld_status;
  logic [cdc_pkg::C100_W-1:0]     ld_c100;
  logic [1:0]                     ld_q4;

  assign ld_year_ext = cdc_pkg::YEAR_EXT_W'(in_year);
  assign ld_ofs      = 8'(ld_year_ext - cdc_pkg::MIN_YEAR);
  assign ld_leap     = (in_year[1:0] == 2'b00) && (ld_year_ext != cdc_pkg::MIN_YEAR) &&
                       (ld_year_ext != cdc_pkg::MAX_LOAD_YEAR);

  always_comb begin
    if (in_month < cdc_pkg::FIRST_MONTH || in_month > cdc_pkg::DEC) begin
      ld_status = cdc_pkg::ST_BAD_MONTH;
    end else if (ld_year_ext < cdc_pkg::MIN_YEAR || ld_year_ext > cdc_pkg::MAX_LOAD_YEAR) begin
      ld_status = cdc_pkg::ST_BAD_YEAR;
    end else if (in_day < cdc_pkg::FIRST_DAY ||
                 in_day > cdc_pkg::days_in(in_month, ld_leap)) begin
      ld_status = cdc_pkg::ST_BAD_DAY;
    end else begin
      ld_status = cdc_pkg::ST_OK;
    end
  end

  // year within century and century modulo 4, for a year already in range
  always_comb begin
    if (ld_year_ext < cdc_pkg::MID_YEAR) begin
      ld_c100 = ld_ofs[cdc_pkg::C100_W-1:0];
      ld_q4   = cdc_pkg::Q4_1900;
    end else if (ld_year_ext < cdc_pkg::MAX_LOAD_YEAR) begin
      ld_c100 = cdc_pkg::C100_W'(ld_ofs - cdc_pkg::CENTURY_SPAN);
      ld_q4   = cdc_pkg::Q4_2000;
    end else begin
      ld_c100 = '0;
      ld_q4   = cdc_pkg::Q4_2100;
    end
  end

  // one-day stepper
  logic       cur_leap;
  logic [4:0] cur_len;
  logic       at_end;

  assign cur_leap = (year_r[1:0] == 2'b00) && ((c100_r != '0) || (q4_r == 2'b00));
  assign cur_len  = cdc_pkg::days_in(month_r, cur_leap);
  assign at_end   = (day_r >= cur_len) && (month_r == cdc_pkg::DEC) && (year_r == MAX_YEAR);

  assign dp_stat.done     = (cnt_r == '0) || (stat_r == cdc_pkg::ST_OVERFLOW);
  assign dp_stat.out_busy = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_r   <= cdc_pkg::FIRST_DAY;
      month_r <= cdc_pkg::FIRST_MONTH;
      year_r  <= YEAR_WIDTH'(cdc_pkg::MIN_YEAR);
      c100_r  <= '0;
      q4_r    <= cdc_pkg::Q4_1900;
      stat_r  <= cdc_pkg::ST_OK;
    end else if (cmd.load) begin
      stat_r <= ld_status;
      if (ld_status == cdc_pkg::ST_OK) begin
        day_r   <= in_day;
        month_r <= in_month;
        year_r  <= in_year;
        c100_r  <= ld_c100;
        q4_r    <= ld_q4;
      end
    end else if (cmd.adv) begin
      stat_r <= cdc_pkg::ST_OK;
    end else if (cmd.step) begin
      if (day_r < cur_len) begin
        day_r <= day_r + 5'd1;
      end else if (month_r < cdc_pkg::DEC) begin
        month_r <= month_r + 4'd1;
        day_r   <= cdc_pkg::FIRST_DAY;
      end else if (!at_end) begin
        year_r  <= year_r + YEAR_WIDTH'(1);
        month_r <= cdc_pkg::FIRST_MONTH;
        day_r   <= cdc_pkg::FIRST_DAY;
        if (c100_r == cdc_pkg::C100_LAST) begin
          c100_r <= '0;
          q4_r   <= q4_r + 2'd1;
        end else begin
          c100_r <= c100_r + cdc_pkg::C100_W'(1);
        end
      end else begin
        stat_r <= cdc_pkg::ST_OVERFLOW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.adv) begin
      cnt_r <= in_count;
    end else if (cmd.step && !at_end) begin
      cnt_r <= cnt_r - COUNT_WIDTH'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_day_r    <= day_r;
      out_month_r  <= month_r;
      out_year_r   <= year_r;
      out_status_r <= stat_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_day    = out_day_r;
  assign out_month  = out_month_r;
  assign out_year   = out_year_r;
  assign out_status = out_status_r;

endmodule
`default_nettype wire

[src/calendar_date_counter_core.sv]
// top level of the calendar date counter
// Holds a Gregorian date (reset 1 January 1900) and takes one item at a time.
// A load is checked (month, then year 1900-2100, then day) and its result is
// registered and then emitted from the finish state. An advance moves the date
// one day per cycle through the date registers' stepper until day_count days
// have passed, and its result is then emitted from the finish state. Stepping
// past 31 December of year 2^YEAR_WIDTH - 1 stops there with status 4. The
// result sits in an output register, so a new item is taken while it waits.
`default_nettype none
module calendar_date_counter_core #(
  parameter int COUNT_WIDTH = cdc_pkg::COUNT_WIDTH_DEF,
  parameter int YEAR_WIDTH  = cdc_pkg::YEAR_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  cdc_in_if.sink    in_if,
  cdc_out_if.source out_if
);

  cdc_pkg::cmd_t     cmd;
  cdc_pkg::dp_stat_t dp_stat;

  cdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_opcode (in_if.opcode),
    .in_ready  (in_if.ready),
    .dp_stat   (dp_stat),
    .cmd       (cmd)
  );

  cdc_dpath #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .YEAR_WIDTH  (YEAR_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .dp_stat    (dp_stat),
    .in_month   (in_if.new_month),
    .in_day     (in_if.new_day),
    .in_year    (in_if.new_year),
    .in_count   (in_if.day_count),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .out_day    (out_if.cur_day),
    .out_month  (out_if.cur_month),
    .out_year   (out_if.cur_year),
    .out_status (out_if.status)
  );

endmodule
`default_nettype wire

[src/cdc_checker.sv]
// port-level checks for the calendar date counter and their bind
`default_nettype none
module cdc_checker #(
  parameter int YEAR_WIDTH = cdc_pkg::YEAR_WIDTH_DEF
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [4:0]            out_day,
  input wire logic [3:0]            out_month,
  input wire logic [YEAR_WIDTH-1:0] out_year,
  input wire logic [2:0]            out_status
);

  logic [cdc_pkg::YEAR_EXT_W-1:0] year_ext;
  assign year_ext = cdc_pkg::YEAR_EXT_W'(out_year);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_day) && $stable(out_month) &&
    $stable(out_year) && $stable(out_status))
    else $error("stalled result changed");

  // date fields are in range, with February allowed 29 days in any year
  a_date_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_month >= cdc_pkg::FIRST_MONTH && out_month <= cdc_pkg::DEC &&
    out_day >= cdc_pkg::FIRST_DAY &&
    out_day <= cdc_pkg::days_in(out_month, 1'b1) && year_ext >= cdc_pkg::MIN_YEAR)
    else $error("illegal date in result");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == cdc_pkg::ST_OK || out_status == cdc_pkg::ST_BAD_MONTH ||
    out_status == cdc_pkg::ST_BAD_YEAR || out_status == cdc_pkg::ST_BAD_DAY ||
    out_status == cdc_pkg::ST_OVERFLOW)
    else $error("illegal status code");

  // overflow only at the last date
  a_overflow_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == cdc_pkg::ST_OVERFLOW |->
    out_year == {YEAR_WIDTH{1'b1}} && out_month == cdc_pkg::DEC && out_day == 5'd31)
    else $error("overflow away from the last date");

endmodule

bind calendar_date_counter_core cdc_checker #(
  .YEAR_WIDTH (YEAR_WIDTH)
) u_cdc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_day    (out_if.cur_day),
  .out_month  (out_if.cur_month),
  .out_year   (out_if.cur_year),
  .out_status (out_if.status)
);
`default_nettype wire
